// ===== hw/rtl/fab_pkg.sv =====
// Shared types, constants and helpers for the framebuffer alpha blend engine.
// Used by fab_front, fab_queue, fab_back and framebuffer_alpha_blend_pixel.
// No dependencies.
package fab_pkg;

  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [8:0]  FbWidthRst   = 9'd256;
  localparam logic [8:0]  FbHeightRst  = 9'd256;
  localparam logic [31:0] OpaqueAlpha  = 32'hFF00_0000;
  localparam logic [7:0]  FullCov      = 8'hFF;
  localparam logic [7:0]  ZeroCov      = 8'h00;

  typedef enum logic [1:0] {
    REQ_GLYPH = 2'd0,
    REQ_RECT  = 2'd1,
    REQ_READ  = 2'd2
  } req_e;

  typedef enum logic [0:0] {
    CFG_FB_WIDTH  = 1'b0,
    CFG_FB_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_CLIP,
    OP_SKIP,
    OP_FILL,
    OP_BLEND,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  coverage;
    logic [23:0] fg_color;
    logic        eos;
  } item_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        written;
    logic        clipped;
    logic        eos;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_RES
  } back_state_e;

  // Exact floor(s / 255) for s <= 255*255.
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = {1'b0, s} + 17'd1 + {9'd0, s[15:8]};
    return t[15:8];
  endfunction

endpackage

// ===== hw/rtl/fab_front.sv =====
// Front end: holds the bound registers, clips coordinates, computes the
// store address and classifies each request. Depends on fab_pkg.
module fab_front #(
  parameter int unsigned MAX_WIDTH  = fab_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = fab_pkg::MaxHeightDef,
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [8:0]            cfg_wdata_i,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0]            req_type_i,
  input  logic [10:0]           pixel_x_i,
  input  logic [10:0]           pixel_y_i,
  input  logic [7:0]            coverage_i,
  input  logic [23:0]           fg_color_i,
  input  logic                  end_of_shape_i,
  input  fab_pkg::queue_status_t q_status_i,
  output logic                  push_o,
  output fab_pkg::item_t        item_o,
  output logic [AW-1:0]         addr_o
);

  localparam int unsigned WBW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HBW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned MB  = (WBW > HBW) ? WBW : HBW;
  localparam int unsigned CW  = (MB > 11) ? MB : 11;

  logic [8:0]    fb_width_q, fb_width_d;
  logic [8:0]    fb_height_q, fb_height_d;
  logic [CW-1:0] w_eff, h_eff, xz, yz;
  logic [2*CW-1:0] lin_addr;
  logic          clipped;

  always_comb begin
    fb_width_d  = fb_width_q;
    fb_height_d = fb_height_q;
    if (cfg_we_i) begin
      case (fab_pkg::cfg_idx_e'(cfg_idx_i))
        fab_pkg::CFG_FB_WIDTH:  fb_width_d  = cfg_wdata_i;
        fab_pkg::CFG_FB_HEIGHT: fb_height_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_width_q  <= fab_pkg::FbWidthRst;
      fb_height_q <= fab_pkg::FbHeightRst;
    end else begin
      fb_width_q  <= fb_width_d;
      fb_height_q <= fb_height_d;
    end
  end

  // Bounds saturate to the store geometry.
  always_comb begin
    w_eff = (CW'(fb_width_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(fb_width_q);
    h_eff = (CW'(fb_height_q) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(fb_height_q);
    xz    = CW'(pixel_x_i[9:0]);
    yz    = CW'(pixel_y_i[9:0]);
    clipped = pixel_x_i[10] || pixel_y_i[10] || (xz >= w_eff) || (yz >= h_eff);
    lin_addr = (2*CW)'(yz * w_eff) + (2*CW)'(xz);
    addr_o   = clipped ? '0 : lin_addr[AW-1:0];
  end

  always_comb begin
    item_o.coverage = coverage_i;
    item_o.fg_color = fg_color_i;
    item_o.eos      = end_of_shape_i;
    if (clipped) begin
      item_o.op = fab_pkg::OP_CLIP;
    end else begin
      case (fab_pkg::req_e'(req_type_i))
        fab_pkg::REQ_GLYPH: begin
          if (coverage_i == fab_pkg::FullCov) begin
            item_o.op = fab_pkg::OP_FILL;
          end else if (coverage_i == fab_pkg::ZeroCov) begin
            item_o.op = fab_pkg::OP_SKIP;
          end else begin
            item_o.op = fab_pkg::OP_BLEND;
          end
        end
        fab_pkg::REQ_RECT: item_o.op = fab_pkg::OP_BLEND;
        default:           item_o.op = fab_pkg::OP_READ;
      endcase
    end
  end

  assign ready_o = !q_status_i.full;
  assign push_o  = valid_i && !q_status_i.full;

endmodule

// ===== hw/rtl/fab_queue.sv =====
// Short FIFO between front and back ends; carries classified items and
// their store addresses. Depends on fab_pkg.
module fab_queue #(
  parameter int unsigned AW = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fab_pkg::item_t         item_i,
  input  logic [AW-1:0]          addr_i,
  input  logic                   pop_i,
  output fab_pkg::item_t         item_o,
  output logic [AW-1:0]          addr_o,
  output fab_pkg::queue_status_t status_o
);

  localparam int unsigned PW = $clog2(fab_pkg::QueueDepth);

  fab_pkg::item_t item_q [fab_pkg::QueueDepth];
  logic [AW-1:0]  addr_q [fab_pkg::QueueDepth];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PW:0]    count_q, count_d;
  logic           do_push, do_pop;

  assign status_o.full  = (count_q == (PW+1)'(fab_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign item_o  = item_q[rd_ptr_q];
  assign addr_o  = addr_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      item_q[wr_ptr_q] <= item_i;
      addr_q[wr_ptr_q] <= addr_i;
    end
  end

endmodule

// ===== hw/rtl/fab_back.sv =====
// Back end: pixel store, read / multiply / divide sequencer and the output
// register. Depends on fab_pkg.
module fab_back #(
  parameter int unsigned MAX_WIDTH  = fab_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = fab_pkg::MaxHeightDef,
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fab_pkg::queue_status_t q_status_i,
  input  fab_pkg::item_t         item_i,
  input  logic [AW-1:0]          addr_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output fab_pkg::result_t       result_o
);

  fab_pkg::back_state_e state_q, state_d;
  fab_pkg::item_t       item_q;
  logic [AW-1:0]        addr_q;
  logic [31:0]          mem [DEPTH];
  logic [31:0]          rdata_q, bg_q;
  logic [15:0]          sum_q [3];
  logic [15:0]          sum_d [3];
  logic [7:0]           inv_cov;
  fab_pkg::result_t     res, out_q;
  logic                 out_valid_q, out_free, fire, mem_we;

  assign out_free = !out_valid_q || ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      fab_pkg::BK_IDLE: if (!q_status_i.empty) state_d = fab_pkg::BK_MUL;
      fab_pkg::BK_MUL:  state_d = fab_pkg::BK_RES;
      fab_pkg::BK_RES:  if (out_free) state_d = fab_pkg::BK_IDLE;
      default:          state_d = fab_pkg::BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o  = 1'b0;
    fire   = 1'b0;
    mem_we = 1'b0;
    case (state_q)
      fab_pkg::BK_IDLE: pop_o = !q_status_i.empty;
      fab_pkg::BK_RES: begin
        fire   = out_free;
        mem_we = out_free && res.written;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fab_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Store: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= res.pixel;
    if (pop_o) rdata_q <= mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= item_i;
      addr_q <= addr_i;
    end
  end

  // Per-channel a*fg + (255-a)*bg.
  assign inv_cov = ~item_q.coverage;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = 16'(item_q.coverage * item_q.fg_color[8*c +: 8])
               + 16'(inv_cov * rdata_q[8*c +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fab_pkg::BK_MUL) begin
      for (int c = 0; c < 3; c++) sum_q[c] <= sum_d[c];
      bg_q <= rdata_q;
    end
  end

  always_comb begin
    res.pixel   = '0;
    res.written = 1'b0;
    res.clipped = 1'b0;
    res.eos     = item_q.eos;
    case (item_q.op)
      fab_pkg::OP_CLIP: res.clipped = 1'b1;
      fab_pkg::OP_FILL: begin
        res.pixel   = fab_pkg::OpaqueAlpha | {8'd0, item_q.fg_color};
        res.written = 1'b1;
      end
      fab_pkg::OP_BLEND: begin
        res.pixel   = {fab_pkg::OpaqueAlpha[31:24], fab_pkg::div255(sum_q[2]),
                       fab_pkg::div255(sum_q[1]), fab_pkg::div255(sum_q[0])};
        res.written = 1'b1;
      end
      fab_pkg::OP_READ: res.pixel = bg_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_q <= res;
  end

  assign valid_o  = out_valid_q;
  assign result_o = out_q;

endmodule

// ===== hw/rtl/framebuffer_alpha_blend_pixel.sv =====
// Top level of the per-pixel alpha blend engine over an ARGB framebuffer.
// Instantiates fab_front, fab_queue and fab_back; depends on fab_pkg.
//
// Usage:
//  - Slave stream s_axis_*: one pixel request per transaction. tuser holds
//    the request type (glyph, rect, read), tlast marks the last pixel of a
//    shape, tdata the coordinate, coverage and foreground color.
//  - Master stream m_axis_*: exactly one result per request, in order.
//    tdata is the pixel written or read, tuser the written/clipped flags,
//    tlast the copied end-of-shape marker.
//  - Config port: cfg_we_i writes fb_width (index 0) or fb_height (index 1),
//    taken at any clock edge; write only while no request is in flight.
//  - Path: queue, store read, multiply, divide / write-back, output register.
//  - The back end takes one pixel at a time: it runs store read, channel
//    multiply and divide-by-255 / write-back in sequence on the one store
//    port, so a read-modify-write completes before the next read.
//  - The front end clips and computes the address while the back end works;
//    a 2-entry queue between them absorbs short bursts. s_axis_tready drops
//    whenever the queue holds two requests, so a back-to-back sender is held
//    to the pace of the back end; with a stalled receiver the queue, back end
//    and output register fill up and hold; nothing is lost.
//  - Reset clears the control state and sets both bounds to 256. Store
//    contents are undefined until written; no clearing pass is made.
module framebuffer_alpha_blend_pixel #(
  parameter int unsigned MAX_WIDTH  = fab_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = fab_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [10:0] pixel_x, [21:11] pixel_y, [29:22] coverage, [53:30] fg_color, [55:54] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] pixel_value
  output logic [31:0] m_axis_tdata,
  // [0] was_written, [1] was_clipped
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  fab_pkg::queue_status_t q_status;
  fab_pkg::item_t         front_item, head_item;
  fab_pkg::result_t       result;
  logic [AW-1:0]          front_addr, head_addr;
  logic                   push, pop;

  fab_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_i        (s_axis_tvalid),
    .ready_o        (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .pixel_x_i      (s_axis_tdata[10:0]),
    .pixel_y_i      (s_axis_tdata[21:11]),
    .coverage_i     (s_axis_tdata[29:22]),
    .fg_color_i     (s_axis_tdata[53:30]),
    .end_of_shape_i (s_axis_tlast),
    .q_status_i     (q_status),
    .push_o         (push),
    .item_o         (front_item),
    .addr_o         (front_addr)
  );

  fab_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .addr_i   (front_addr),
    .pop_i    (pop),
    .item_o   (head_item),
    .addr_o   (head_addr),
    .status_o (q_status)
  );

  fab_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .item_i     (head_item),
    .addr_i     (head_addr),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .result_o   (result)
  );

  assign m_axis_tdata = result.pixel;
  assign m_axis_tuser = {result.clipped, result.written};
  assign m_axis_tlast = result.eos;

  // A clipped pixel never touches the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("clipped result flagged as written");

  // Every written pixel carries opaque alpha.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[31:24] == 8'hFF))
    else $error("written pixel without opaque alpha");

  // A clipped result returns a zero pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 32'd0))
    else $error("clipped result with nonzero pixel");

  // Queue full must stall the request stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full |-> !s_axis_tready)
    else $error("request accepted while queue full");

endmodule
